[rtl/sce_pkg.sv]
// Shared types, widths and softplus table generator for the sigmoid
// cross-entropy loss block. Depends on nothing; used by the top level.
package sce_pkg;

  // Default number of table intervals across |x| = 0 .. 16.0
  localparam int SOFTPLUS_ENTRIES_DEF = 64;

  // Table sample width: ln(2) in Q5.11 is the largest sample (1420)
  localparam int SP_W = 11;

  // Q2.30 helpers used while building the table
  localparam longint Q30_ONE  = 64'sd1 << 30;
  localparam longint Q30_HALF = 64'sd1 << 29;

  typedef struct packed {
    logic signed [15:0] logit;
    logic        [15:0] label;
    logic               last_in;
  } sce_in_t;

  typedef struct packed {
    logic [15:0] loss;
    logic        last_out;
  } sce_out_t;

  // Restoring long division of nonnegative values, elaboration use only
  function automatic longint udiv64(longint n, longint d);
    logic [63:0] num;
    logic [63:0] den;
    logic [63:0] rem;
    logic [63:0] quo;
    num = n;
    den = d;
    rem = '0;
    quo = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[62:0], num[i]};
      if (rem >= den) begin
        rem = rem - den;
        quo[i] = 1'b1;
      end
    end
    return longint'(quo);
  endfunction

  // Divide a nonnegative value by one of the small series divisors
  function automatic longint div_small(longint v, int d);
    longint q;
    case (d)
      1:       q = v;
      2:       q = v / 2;
      3:       q = v / 3;
      4:       q = v / 4;
      5:       q = v / 5;
      6:       q = v / 6;
      7:       q = v / 7;
      8:       q = v / 8;
      9:       q = v / 9;
      10:      q = v / 10;
      11:      q = v / 11;
      12:      q = v / 12;
      13:      q = v / 13;
      15:      q = v / 15;
      17:      q = v / 17;
      19:      q = v / 19;
      21:      q = v / 21;
      23:      q = v / 23;
      25:      q = v / 25;
      27:      q = v / 27;
      29:      q = v / 29;
      31:      q = v / 31;
      33:      q = v / 33;
      35:      q = v / 35;
      37:      q = v / 37;
      39:      q = v / 39;
      41:      q = v / 41;
      default: q = 0;
    endcase
    return q;
  endfunction

  // ln(1 + exp(-t)) for t in Q30, result rounded half up to Q11
  function automatic longint softplus_neg_q11(longint t);
    longint u;
    longint term;
    longint pos;
    longint neg;
    longint e;
    longint s;
    longint s2;
    longint p;
    longint acc;
    longint ln;
    u    = t >>> 6;
    term = Q30_ONE;
    pos  = Q30_ONE;
    neg  = 0;
    // exp(-t/64) by Taylor series
    for (int i = 1; i <= 12; i++) begin
      term = div_small((term * u) >>> 30, i);
      if ((i % 2) == 1) begin
        neg = neg + term;
      end else begin
        pos = pos + term;
      end
    end
    e = pos - neg;
    if (e < 0) begin
      e = 0;
    end
    if (e > Q30_ONE) begin
      e = Q30_ONE;
    end
    // raise to the 64th power by repeated squaring
    for (int i = 0; i < 6; i++) begin
      e = (e * e + Q30_HALF) >>> 30;
    end
    // ln(1+e) = 2*atanh(e/(2+e))
    s   = udiv64(e << 30, 2 * Q30_ONE + e);
    s2  = (s * s) >>> 30;
    p   = s;
    acc = 0;
    for (int i = 0; i <= 20; i++) begin
      acc = acc + div_small(p, 2 * i + 1);
      p   = (p * s2) >>> 30;
    end
    ln = 2 * acc;
    return (ln + (64'sd1 <<< 18)) >>> 19;
  endfunction

  // Table sample k for a table of the given number of intervals
  function automatic logic [SP_W-1:0] sp_entry(int k, int entries);
    longint t;
    t = udiv64(longint'(k) << 34, longint'(entries));
    return SP_W'(softplus_neg_q11(t));
  endfunction

endpackage

[rtl/sigmoid_cross_entropy_loss.sv]
// Throughput: one request per cycle while result_ready is held high; four
// register stages, the last one the output register, each stage advancing
// when the one after it frees up.
// Reset (rst, synchronous) clears the stage valid bits only; the softplus
// table is a constant built at elaboration.
// Top level of the sigmoid cross-entropy loss block; uses sce_pkg.
module sigmoid_cross_entropy_loss #(
  parameter int SOFTPLUS_ENTRIES = sce_pkg::SOFTPLUS_ENTRIES_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_ready,
  input  sce_pkg::sce_in_t item,
  output logic             result_valid,
  input  logic             result_ready,
  output sce_pkg::sce_out_t result
);

  localparam int SP_W  = sce_pkg::SP_W;
  localparam int IDX_W = $clog2(SOFTPLUS_ENTRIES + 1);
  localparam int P_W   = 15 + IDX_W;
  localparam int V_W   = SP_W + 17;

  // Softplus table, one sample per interval end
  logic [SP_W-1:0] rom [SOFTPLUS_ENTRIES+1];

  for (genvar k = 0; k <= SOFTPLUS_ENTRIES; k++) begin : g_rom
    assign rom[k] = sce_pkg::sp_entry(k, SOFTPLUS_ENTRIES);
  end

  // Stage handshake
  logic s1_valid;
  logic s2_valid;
  logic s3_valid;
  logic s4_valid;
  logic s1_ready;
  logic s2_ready;
  logic s3_ready;
  logic s4_ready;

  assign s4_ready   = !s4_valid || result_ready;
  assign s3_ready   = !s3_valid || s4_ready;
  assign s2_ready   = !s2_valid || s3_ready;
  assign s1_ready   = !s1_valid || s2_ready;
  assign item_ready = s1_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid <= item_valid;
      end
      if (s2_ready) begin
        s2_valid <= s1_valid;
      end
      if (s3_ready) begin
        s3_valid <= s2_valid;
      end
      if (s4_ready) begin
        s4_valid <= s3_valid;
      end
    end
  end

  // Stage 1: magnitude, positive part and the x*z product
  logic signed [16:0] x_ext;
  logic        [16:0] mag_c;
  logic signed [32:0] xz_c;
  logic        [16:0] s1_mag;
  logic        [14:0] s1_pos;
  logic signed [32:0] s1_xz;
  logic               s1_last;

  always_comb begin
    x_ext = {item.logit[15], item.logit};
    mag_c = x_ext[16] ? 17'(-x_ext) : 17'(x_ext);
    xz_c  = item.logit * $signed({1'b0, item.label});
  end

  always_ff @(posedge clk) begin
    if (s1_ready) begin
      s1_mag  <= mag_c;
      s1_pos  <= item.logit[15] ? 15'd0 : item.logit[14:0];
      s1_xz   <= xz_c;
      s1_last <= item.last_in;
    end
  end

  // Stage 2: table index and fraction, read both neighbor samples
  logic [P_W-1:0]   p_c;
  logic [IDX_W-1:0] idx_c;
  logic [IDX_W-1:0] idx1_c;
  logic [SP_W-1:0]  s2_t0;
  logic [SP_W-1:0]  s2_t1;
  logic [14:0]      s2_frac;
  logic [14:0]      s2_pos;
  logic signed [32:0] s2_xz;
  logic             s2_last;

  always_comb begin
    p_c    = P_W'(s1_mag) * P_W'(SOFTPLUS_ENTRIES);
    idx_c  = p_c[15 +: IDX_W];
    idx1_c = (idx_c == IDX_W'(SOFTPLUS_ENTRIES)) ? idx_c : idx_c + IDX_W'(1);
  end

  always_ff @(posedge clk) begin
    if (s2_ready) begin
      s2_t0   <= rom[idx_c];
      s2_t1   <= rom[idx1_c];
      s2_frac <= p_c[14:0];
      s2_pos  <= s1_pos;
      s2_xz   <= s1_xz;
      s2_last <= s1_last;
    end
  end

  // Stage 3: linear interpolation, t0*32768 + (t1-t0)*f, rounded to Q11
  logic signed [SP_W:0]    diff_c;
  logic signed [SP_W+16:0] prod_c;
  logic signed [V_W-1:0]   interp_c;
  logic [SP_W-1:0]         s3_sp;
  logic [14:0]             s3_pos;
  logic signed [32:0]      s3_xz;
  logic                    s3_last;

  always_comb begin
    diff_c   = $signed({1'b0, s2_t1}) - $signed({1'b0, s2_t0});
    prod_c   = diff_c * $signed({1'b0, s2_frac});
    interp_c = $signed({2'b00, s2_t0, 15'd0}) + V_W'(prod_c) + V_W'(16384);
  end

  always_ff @(posedge clk) begin
    if (s3_ready) begin
      s3_sp   <= interp_c[15 +: SP_W];
      s3_pos  <= s2_pos;
      s3_xz   <= s2_xz;
      s3_last <= s2_last;
    end
  end

  // Stage 4: total in Q26, round half up to Q11, clamp to the output range
  logic signed [33:0] total_c;
  logic        [33:0] rnd_c;
  logic        [15:0] loss_c;

  always_comb begin
    total_c = $signed({8'd0, s3_sp, 15'd0}) + $signed({4'd0, s3_pos, 15'd0})
              - 34'(s3_xz);
    rnd_c   = 34'(total_c) + 34'd16384;
    if (total_c[33]) begin
      loss_c = 16'd0;
    end else if (rnd_c[32:31] != 2'b00) begin
      loss_c = 16'hFFFF;
    end else begin
      loss_c = rnd_c[30:15];
    end
  end

  always_ff @(posedge clk) begin
    if (s4_ready) begin
      result.loss     <= loss_c;
      result.last_out <= s3_last;
    end
  end

  assign result_valid = s4_valid;

endmodule
